// ----- rtl/alu8f_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alu8f_pkg: shared types and constants of the 8-bit alu flags unit
// operation codes, item layouts and the decimal adjust limits
// ----------------------------------------------------------------------------
package alu8f_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  typedef enum logic [3:0] {
    OP_CLR = 4'd0,
    OP_ADD = 4'd1,
    OP_AND = 4'd2,
    OP_NEG = 4'd3,
    OP_DAA = 4'd4,
    OP_NOT = 4'd5,
    OP_OR  = 4'd6,
    OP_RLC = 4'd7,
    OP_RRC = 4'd8,
    OP_SUB = 4'd9,
    OP_XOR = 4'd10
  } op_e;

  // decimal adjust limits on a nibble
  localparam logic [NibW-1:0] DaaFixLimit = 4'd9;
  localparam logic [NibW-1:0] DaaFlagLimit = 4'd3;
  localparam logic [ByteW-1:0] DaaLowAdd  = 8'h06;
  localparam logic [ByteW-1:0] DaaHighAdd = 8'h60;

  // packed so that the last field lands in the lowest bits
  typedef struct packed {
    logic             aux_carry_in;
    logic             carry_in;
    logic [ByteW-1:0] operand_b;
    logic [ByteW-1:0] operand_a;
    logic [3:0]       action;
  } in_item_t;

  typedef struct packed {
    logic             sign_flag;
    logic             parity_flag;
    logic             zero_flag;
    logic             aux_carry_out;
    logic             carry_out;
    logic [ByteW-1:0] result;
  } out_item_t;

  localparam int unsigned InItemW  = $bits(in_item_t);
  localparam int unsigned OutItemW = $bits(out_item_t);
  localparam int unsigned InDataW  = ((InItemW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((OutItemW + 7) / 8) * 8;

  function automatic logic even_parity(input logic [ByteW-1:0] value);
    even_parity = ~(^value);
  endfunction

endpackage : alu8f_pkg
`default_nettype wire

// ----- rtl/alu8f_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alu8f_stage: pipeline register with valid/ready flow control
// holds one item, takes a new one whenever it is empty or the held item leaves
// ----------------------------------------------------------------------------
module alu8f_stage #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [Width-1:0]      data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule : alu8f_stage
`default_nettype wire

// ----- rtl/alu8f_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alu8f_core: combinational 8-bit alu with 8080-style flags
// computes the result byte, carry, aux carry, zero, parity and sign
// ----------------------------------------------------------------------------
module alu8f_core (
  input  wire alu8f_pkg::in_item_t item_i,
  output alu8f_pkg::out_item_t     item_o
);

  logic [alu8f_pkg::ByteW:0]     add_sum;
  logic [alu8f_pkg::ByteW:0]     sub_diff;
  logic [alu8f_pkg::NibW:0]      add_nib;
  logic [alu8f_pkg::NibW:0]      sub_nib;
  logic                          daa_low_fix;
  logic                          daa_high_fix;
  logic [alu8f_pkg::ByteW-1:0]   daa_mid;
  logic [alu8f_pkg::ByteW-1:0]   daa_res;
  logic [alu8f_pkg::ByteW-1:0]   res;
  logic                          cy;
  logic                          ac;
  logic                          set_zps;

  assign add_sum  = {1'b0, item_i.operand_a} + {1'b0, item_i.operand_b}
                  + {{alu8f_pkg::ByteW{1'b0}}, item_i.carry_in};
  // bit 8 of the 9-bit difference is the borrow
  assign sub_diff = {1'b0, item_i.operand_a} - {1'b0, item_i.operand_b}
                  - {{alu8f_pkg::ByteW{1'b0}}, item_i.carry_in};
  assign add_nib  = {1'b0, item_i.operand_a[3:0]} + {1'b0, item_i.operand_b[3:0]}
                  + {{alu8f_pkg::NibW{1'b0}}, item_i.carry_in};
  // half carry of subtract is taken from the nibble sum
  assign sub_nib  = {1'b0, item_i.operand_a[3:0]} + {1'b0, item_i.operand_b[3:0]};

  assign daa_low_fix  = (item_i.operand_a[3:0] > alu8f_pkg::DaaFixLimit)
                     || item_i.aux_carry_in;
  assign daa_mid      = daa_low_fix ? item_i.operand_a + alu8f_pkg::DaaLowAdd
                                    : item_i.operand_a;
  assign daa_high_fix = (daa_mid[7:4] > alu8f_pkg::DaaFixLimit) || item_i.carry_in;
  assign daa_res      = daa_high_fix ? daa_mid + alu8f_pkg::DaaHighAdd : daa_mid;

  always_comb begin
    res     = item_i.operand_a;
    cy      = 1'b0;
    ac      = 1'b0;
    set_zps = 1'b1;
    case (item_i.action)
      alu8f_pkg::OP_CLR: begin
        res = '0;
      end
      alu8f_pkg::OP_ADD: begin
        res = add_sum[alu8f_pkg::ByteW-1:0];
        cy  = add_sum[alu8f_pkg::ByteW];
        ac  = add_nib[alu8f_pkg::NibW];
      end
      alu8f_pkg::OP_AND: begin
        res = item_i.operand_a & item_i.operand_b;
      end
      alu8f_pkg::OP_NEG: begin
        res     = -item_i.operand_a;
        set_zps = 1'b0;
      end
      alu8f_pkg::OP_DAA: begin
        res = daa_res;
        ac  = daa_low_fix && (item_i.operand_a[3:0] > alu8f_pkg::DaaFlagLimit);
        cy  = daa_high_fix && (daa_mid[7:4] > alu8f_pkg::DaaFlagLimit);
      end
      alu8f_pkg::OP_NOT: begin
        res     = ~item_i.operand_a;
        set_zps = 1'b0;
      end
      alu8f_pkg::OP_OR: begin
        res = item_i.operand_a | item_i.operand_b;
      end
      alu8f_pkg::OP_RLC: begin
        res     = {item_i.operand_a[6:0], item_i.carry_in};
        cy      = item_i.operand_a[7];
        set_zps = 1'b0;
      end
      alu8f_pkg::OP_RRC: begin
        res     = {item_i.carry_in, item_i.operand_a[7:1]};
        cy      = item_i.operand_a[0];
        set_zps = 1'b0;
      end
      alu8f_pkg::OP_SUB: begin
        res = sub_diff[alu8f_pkg::ByteW-1:0];
        cy  = sub_diff[alu8f_pkg::ByteW];
        ac  = sub_nib[alu8f_pkg::NibW];
      end
      alu8f_pkg::OP_XOR: begin
        res = item_i.operand_a ^ item_i.operand_b;
      end
      default: begin
        // undefined codes pass operand_a through, with zero, parity and sign from it and carries clear
        res = item_i.operand_a;
      end
    endcase
  end

  assign item_o.result        = res;
  assign item_o.carry_out     = cy;
  assign item_o.aux_carry_out = ac;
  assign item_o.zero_flag     = set_zps && (res == '0);
  assign item_o.parity_flag   = set_zps && alu8f_pkg::even_parity(res);
  assign item_o.sign_flag     = set_zps && res[alu8f_pkg::ByteW-1];

endmodule : alu8f_core
`default_nettype wire

// ----- rtl/alu8_flags_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// path: an item accepted into the input register passes the alu and leaves from the result register
// throughput: 1 item per cycle while results are taken, the alu is one level of logic between the two registers
// the input side is ready unless both registers hold an item and the result is not taken
// reset: both registers drop their valid bits; there is no other state
// ----------------------------------------------------------------------------
// alu8_flags_unit: 8-bit alu with 8080-style flags on a stream interface
// registered input item, combinational alu, registered result item
// ----------------------------------------------------------------------------
module alu8_flags_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // action[3:0], operand_a[11:4], operand_b[19:12], carry_in[20],
  // aux_carry_in[21], zero fill[23:22]
  input  wire logic [alu8f_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // result[7:0], carry_out[8], aux_carry_out[9], zero_flag[10],
  // parity_flag[11], sign_flag[12], zero fill[15:13]
  output logic [alu8f_pkg::OutDataW-1:0]      m_axis_tdata_o
);

  alu8f_pkg::in_item_t  in_item;
  alu8f_pkg::in_item_t  held_item;
  alu8f_pkg::out_item_t alu_item;
  alu8f_pkg::out_item_t res_item;
  logic                 held_valid;
  logic                 res_ready;

  assign in_item = s_axis_tdata_i[alu8f_pkg::InItemW-1:0];

  alu8f_stage #(
    .Width (alu8f_pkg::InItemW)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (in_item),
    .valid_o (held_valid),
    .ready_i (res_ready),
    .data_o  (held_item)
  );

  alu8f_core u_core (
    .item_i (held_item),
    .item_o (alu_item)
  );

  alu8f_stage #(
    .Width (alu8f_pkg::OutItemW)
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (held_valid),
    .ready_o (res_ready),
    .data_i  (alu_item),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (res_item)
  );

  assign m_axis_tdata_o = {{(alu8f_pkg::OutDataW - alu8f_pkg::OutItemW){1'b0}}, res_item};

  // a held item always moves to the result register when it has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid && res_ready) |=> m_axis_tvalid_o)
    else $error("held item did not reach the result register");

  // flag-less operations leave zero, parity and sign clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid && (held_item.action == alu8f_pkg::OP_NEG
                 || held_item.action == alu8f_pkg::OP_NOT
                 || held_item.action == alu8f_pkg::OP_RLC
                 || held_item.action == alu8f_pkg::OP_RRC))
    |-> (!alu_item.zero_flag && !alu_item.parity_flag && !alu_item.sign_flag))
    else $error("flags set on an operation that clears them");

  // clear gives zero result with zero and parity set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_valid && held_item.action == alu8f_pkg::OP_CLR)
    |-> (alu_item.result == '0 && alu_item.zero_flag && alu_item.parity_flag
         && !alu_item.carry_out))
    else $error("clear produced a wrong item");

  // while the result register stalls, the input register keeps its held item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i && held_valid) |=> held_valid)
    else $error("held item lost while the result side stalled");

endmodule : alu8_flags_unit
`default_nettype wire
